// File: rtl/core/strict_priority_multi_queue_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the strict priority multi-level queue
// Shared property forms, written once so that every check reports alike.
// ----------------------------------------------------------------------------
`ifndef STRICT_PRIORITY_MULTI_QUEUE_MACROS_SVH
`define STRICT_PRIORITY_MULTI_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SPMQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spmq check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define SPMQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spmq check failed: next-cycle implication");

`endif

// File: rtl/core/spmq_pkg.sv
// ----------------------------------------------------------------------------
// spmq_pkg
// Request and response types and codes of the strict priority multi queue.
// ----------------------------------------------------------------------------
package spmq_pkg;

   // request kinds
   localparam logic [1:0] REQ_ENQ  = 2'd0;
   localparam logic [1:0] REQ_DEQ  = 2'd1;
   localparam logic [1:0] REQ_PEEK = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic [3:0] priority_req;
      logic [7:0] item_id;
   } spmq_req_type;

   typedef struct packed {
      logic [7:0] item_out;
      logic       item_valid;
      logic [1:0] status;
      logic       all_empty;
   } spmq_rsp_type;

endpackage

// File: rtl/core/strict_priority_multi_queue.sv
// ----------------------------------------------------------------------------
// strict_priority_multi_queue
// One FIFO per priority level, level 0 most urgent, with a shared slot RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries enqueue, dequeue and peek requests (valid/ready). An
//   enqueue writes its handle into the tail slot of its level; a level number
//   beyond the last level lands in the least urgent one. Dequeue and peek
//   take the head of the lowest-numbered non-empty level.
//   rsp_* returns exactly one response per request (valid/ready), in order,
//   with the handle, a status code and whether all levels are now empty.
// Pipeline and throughput:
//   A response passes the pending stage and the output register after its
//   request transfer. Requests are taken one per cycle while req_ready is
//   high: in the transfer cycle the slot RAM is written (enqueue) or read into
//   a register (dequeue/peek), and per-level head, tail and count registers update.
// Reset:
//   All levels become empty at once; the slot RAM is not cleared, since a
//   slot is only read after it has been written.
// Stalls:
//   A response waiting in the output register holds; one further response
//   waits in the pending stage, after which req_ready drops.
// ----------------------------------------------------------------------------
`include "strict_priority_multi_queue_macros.svh"

module strict_priority_multi_queue
   import spmq_pkg::*;
#(
   parameter int LEVELS      = 16,
   parameter int LEVEL_DEPTH = 16,
   parameter int ITEM_BITS   = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  spmq_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output spmq_rsp_type rsp_data
);

   localparam int LVL_W  = $clog2(LEVELS);
   localparam int PTR_W  = $clog2(LEVEL_DEPTH);
   localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
   localparam int ADDR_W = LVL_W + PTR_W;
   localparam int SLOTS  = LEVELS * (1 << PTR_W);

   // per-level FIFO control
   logic [PTR_W-1:0] head_ff  [LEVELS];
   logic [PTR_W-1:0] head_in  [LEVELS];
   logic [PTR_W-1:0] tail_ff  [LEVELS];
   logic [PTR_W-1:0] tail_in  [LEVELS];
   logic [CNT_W-1:0] count_ff [LEVELS];
   logic [CNT_W-1:0] count_in [LEVELS];

   // slot RAM
   logic [ITEM_BITS-1:0] slot_mem [SLOTS];
   logic [ITEM_BITS-1:0] rd_data_ff;

   // pending stage and output register
   logic         pend_ff, pend_in;
   logic         pend_item_ff, pend_item_in;
   logic [1:0]   pend_status_ff, pend_status_in;
   logic         pend_empty_ff, pend_empty_in;
   logic         rsp_valid_ff, rsp_valid_in;
   spmq_rsp_type rsp_data_ff, rsp_data_in;

   logic              req_fire;
   logic              is_enq, is_deq, is_peek;
   logic [31:0]       lvl_wide;
   logic [LVL_W-1:0]  enq_lvl;
   logic              enq_full, enq_ok, deq_ok, mem_re;
   logic              top_any;
   logic [LVL_W-1:0]  top_lvl;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic              all_empty_next;
   logic              rsp_load;

   assign req_fire = req_valid && req_ready;
   assign is_enq   = (req_data.req_type == REQ_ENQ);
   assign is_deq   = (req_data.req_type == REQ_DEQ);
   assign is_peek  = (req_data.req_type == REQ_PEEK);

   // saturate the level to the least urgent one
   assign lvl_wide = ({28'd0, req_data.priority_req} >= 32'(LEVELS)) ?
                     32'(LEVELS - 1) : {28'd0, req_data.priority_req};
   assign enq_lvl  = lvl_wide[LVL_W-1:0];

   // lowest-numbered non-empty level
   always_comb begin
      top_any = 1'b0;
      top_lvl = '0;
      for (int l = LEVELS - 1; l >= 0; l--) begin
         if (count_ff[l] != '0) begin
            top_any = 1'b1;
            top_lvl = LVL_W'(l);
         end
      end
   end

   assign enq_full = (count_ff[enq_lvl] == CNT_W'(LEVEL_DEPTH));
   assign enq_ok   = req_fire && is_enq && !enq_full;
   assign deq_ok   = req_fire && is_deq && top_any;
   assign mem_re   = req_fire && (is_deq || is_peek) && top_any;
   assign wr_addr  = {enq_lvl, tail_ff[enq_lvl]};
   assign rd_addr  = {top_lvl, head_ff[top_lvl]};

   always_comb begin
      all_empty_next = 1'b1;
      for (int l = 0; l < LEVELS; l++) begin
         head_in[l]  = head_ff[l];
         tail_in[l]  = tail_ff[l];
         count_in[l] = count_ff[l];
         if (enq_ok && enq_lvl == LVL_W'(l)) begin
            tail_in[l]  = (tail_ff[l] == PTR_W'(LEVEL_DEPTH - 1)) ?
                          '0 : tail_ff[l] + 1'b1;
            count_in[l] = count_ff[l] + 1'b1;
         end
         if (deq_ok && top_lvl == LVL_W'(l)) begin
            head_in[l]  = (head_ff[l] == PTR_W'(LEVEL_DEPTH - 1)) ?
                          '0 : head_ff[l] + 1'b1;
            count_in[l] = count_ff[l] - 1'b1;
         end
         if (count_in[l] != '0) begin
            all_empty_next = 1'b0;
         end
      end
   end

   // move the pending response into the output register when it is free
   assign rsp_load  = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !pend_ff || rsp_load;

   always_comb begin
      pend_in        = pend_ff;
      pend_item_in   = pend_item_ff;
      pend_status_in = pend_status_ff;
      pend_empty_in  = pend_empty_ff;
      if (rsp_load) begin
         pend_in = 1'b0;
      end
      if (req_fire) begin
         pend_in       = 1'b1;
         pend_item_in  = mem_re;
         pend_empty_in = all_empty_next;
         priority if (is_enq && enq_full) begin
            pend_status_in = ST_FULL;
         end else if ((is_deq || is_peek) && !top_any) begin
            pend_status_in = ST_EMPTY;
         end else begin
            pend_status_in = ST_OK;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.item_out   = pend_item_ff ? 8'(rd_data_ff) : 8'd0;
         rsp_data_in.item_valid = pend_item_ff;
         rsp_data_in.status     = pend_status_ff;
         rsp_data_in.all_empty  = pend_empty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enq_ok) begin
         slot_mem[wr_addr] <= ITEM_BITS'(req_data.item_id);
      end
      if (mem_re) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < LEVELS; l++) begin
            head_ff[l]  <= '0;
            tail_ff[l]  <= '0;
            count_ff[l] <= '0;
         end
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_item_ff   <= pend_item_in;
      pend_status_ff <= pend_status_in;
      pend_empty_ff  <= pend_empty_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SPMQ_ASSERT_NOW(a_item_means_ok, clock, reset,
      rsp_valid_ff && rsp_data_ff.item_valid, rsp_data_ff.status == ST_OK)
   `SPMQ_ASSERT_NOW(a_empty_status_all_empty, clock, reset,
      rsp_valid_ff && rsp_data_ff.status == ST_EMPTY, rsp_data_ff.all_empty)
   `SPMQ_ASSERT_NEXT(a_read_gives_item, clock, reset,
      req_fire && (is_deq || is_peek) && top_any, pend_ff && pend_item_ff)
   `SPMQ_ASSERT_NEXT(a_pending_held, clock, reset,
      pend_ff && rsp_valid_ff && !rsp_ready, pend_ff)

endmodule

// File: tb/strict_priority_multi_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// strict_priority_multi_queue_tb
// Sends enqueue, dequeue, peek and unused requests, and mirrors the per-level
// FIFOs in a scoreboard that predicts every response. Each response transfer
// is compared field by field. Directed cases cover the empty queue, priority
// order and a full level. Random bursts then fill and drain the levels under
// several sender and receiver stall mixes.
// ----------------------------------------------------------------------------
module strict_priority_multi_queue_tb;
   import spmq_pkg::*;

   localparam int         LEVELS       = 16;
   localparam int         LEVEL_DEPTH  = 16;
   localparam logic [1:0] REQ_NOP      = 2'd3;
   localparam int         STALL_LIMIT  = 2000;
   localparam int         MAX_REPORTS  = 10;
   localparam int         DRAIN_CYCLES = 8;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   spmq_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   spmq_rsp_type rsp_data;

   // scoreboard copy of the queue
   logic [7:0]   slot_mem [LEVELS][LEVEL_DEPTH];
   int           head_ptr [LEVELS];
   int           tail_ptr [LEVELS];
   int           fill_count [LEVELS];
   spmq_rsp_type awaited_rsp [$];

   int fail_count    = 0;
   int idle_cycles   = 0;
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;

   strict_priority_multi_queue uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int most_urgent_level();
      for (int lv = 0; lv < LEVELS; lv++) begin
         if (fill_count[lv] != 0) return lv;
      end
      return LEVELS;
   endfunction

   function automatic spmq_rsp_type compute_queue_response(spmq_req_type r);
      spmq_rsp_type res;
      int           lv;
      res = '0;
      res.status = ST_OK;
      case (r.req_type)
         REQ_ENQ: begin
            lv = (int'(r.priority_req) >= LEVELS) ? LEVELS - 1 : int'(r.priority_req);
            if (fill_count[lv] >= LEVEL_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               slot_mem[lv][tail_ptr[lv]] = r.item_id;
               tail_ptr[lv] = (tail_ptr[lv] + 1) % LEVEL_DEPTH;
               fill_count[lv]++;
            end
         end
         REQ_DEQ, REQ_PEEK: begin
            lv = most_urgent_level();
            if (lv == LEVELS) begin
               res.status = ST_EMPTY;
            end else begin
               res.item_out   = slot_mem[lv][head_ptr[lv]];
               res.item_valid = 1'b1;
               if (r.req_type == REQ_DEQ) begin
                  head_ptr[lv] = (head_ptr[lv] + 1) % LEVEL_DEPTH;
                  fill_count[lv]--;
               end
            end
         end
         default: ;
      endcase
      res.all_empty = (most_urgent_level() == LEVELS);
      return res;
   endfunction

   // predict on request transfers, check on response transfers
   always @(posedge clock) begin
      spmq_rsp_type want;
      if (reset) begin
         for (int lv = 0; lv < LEVELS; lv++) begin
            head_ptr[lv]   = 0;
            tail_ptr[lv]   = 0;
            fill_count[lv] = 0;
         end
      end else begin
         if (req_valid && req_ready === 1'b1)
            awaited_rsp.push_back(compute_queue_response(req_data));
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: response with none outstanding: item=%0h valid=%0b status=%0d empty=%0b",
                     $realtime, rsp_data.item_out, rsp_data.item_valid, rsp_data.status,
                     rsp_data.all_empty);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_data.item_out !== want.item_out || rsp_data.item_valid !== want.item_valid ||
                   rsp_data.status !== want.status || rsp_data.all_empty !== want.all_empty) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("%0t: mismatch: expected item=%0h valid=%0b status=%0d empty=%0b, got item=%0h valid=%0b status=%0d empty=%0b",
                        $realtime, want.item_out, want.item_valid, want.status, want.all_empty,
                        rsp_data.item_out, rsp_data.item_valid, rsp_data.status,
                        rsp_data.all_empty);
               end
            end
         end
      end
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   task automatic send_request(input spmq_req_type r);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
   endtask

   function automatic spmq_req_type make_req(logic [1:0] kind, logic [3:0] lvl, logic [7:0] item);
      spmq_req_type r;
      r.req_type     = kind;
      r.priority_req = lvl;
      r.item_id      = item;
      return r;
   endfunction

   function automatic spmq_req_type random_request(traffic_mix_type mix, int base_lvl, int spread);
      int         roll;
      int         enq_cut;
      int         deq_cut;
      int         peek_cut;
      logic [1:0] kind;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:  begin enq_cut = 75; deq_cut = 90; peek_cut = 98; end
         MIX_DRAIN: begin enq_cut = 20; deq_cut = 80; peek_cut = 97; end
         default:   begin enq_cut = 45; deq_cut = 80; peek_cut = 96; end
      endcase
      if (roll < enq_cut)       kind = REQ_ENQ;
      else if (roll < deq_cut)  kind = REQ_DEQ;
      else if (roll < peek_cut) kind = REQ_PEEK;
      else                      kind = REQ_NOP;
      return make_req(kind, 4'((base_lvl + $urandom_range(0, spread)) % LEVELS), 8'($urandom));
   endfunction

   task automatic test_empty_queue();
      send_request(make_req(REQ_DEQ, 4'hF, 8'hFF));
      send_request(make_req(REQ_PEEK, 4'h0, 8'h00));
   endtask

   task automatic test_priority_order();
      send_request(make_req(REQ_ENQ, 4'hF, 8'hFF));
      send_request(make_req(REQ_ENQ, 4'h0, 8'h00));
      send_request(make_req(REQ_PEEK, 4'h5, 8'hA5));
      send_request(make_req(REQ_NOP, 4'hA, 8'h5A));
      send_request(make_req(REQ_DEQ, 4'h3, 8'h3C));
      send_request(make_req(REQ_DEQ, 4'hC, 8'hC3));
      send_request(make_req(REQ_DEQ, 4'h0, 8'h00));
   endtask

   // leave level 7 full; the random bursts drain it later
   task automatic test_level_full();
      for (int k = 0; k < LEVEL_DEPTH; k++)
         send_request(make_req(REQ_ENQ, 4'd7, 8'(k * 17)));
      send_request(make_req(REQ_ENQ, 4'd7, 8'hEE));
   endtask

   task automatic test_random_traffic(input int count);
      int              sent;
      int              burst;
      int              base_lvl;
      int              spread;
      traffic_mix_type mix;
      sent = 0;
      while (sent < count) begin
         mix      = traffic_mix_type'($urandom_range(0, 2));
         burst    = $urandom_range(8, 48);
         base_lvl = $urandom_range(0, LEVELS - 1);
         // narrow level ranges fill a level, wide ones spread the load
         spread   = ($urandom_range(0, 3) == 0) ? LEVELS - 1 : $urandom_range(0, 2);
         repeat (burst) begin
            send_request(random_request(mix, base_lvl, spread));
            sent++;
         end
      end
   endtask

   task automatic test_hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_rsp.size() != 0);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_queue();
      test_priority_order();
      test_level_full();

      test_random_traffic(400);
      test_hold_until_drained();

      req_idle_pct = 73;
      test_random_traffic(350);
      test_hold_until_drained();

      req_idle_pct  = 0;
      rsp_stall_pct = 73;
      test_random_traffic(350);
      test_hold_until_drained();

      req_idle_pct  = 37;
      rsp_stall_pct = 37;
      test_random_traffic(350);
      test_hold_until_drained();

      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      test_random_traffic(350);

      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_rsp.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && awaited_rsp.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
